@@ hw/rtl/hftt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hftt_pkg: shared types and constants of the flow table tracker
// Key, link, queue item and payload structs; hash function; FSM codes.
// ----------------------------------------------------------------------------
package hftt_pkg;

    localparam int BUCKET_COUNT = 4096;   // power of two
    localparam int ENTRY_COUNT  = 4096;   // power of two
    localparam int BKT_W        = $clog2(BUCKET_COUNT);
    localparam int ENTRY_W      = $clog2(ENTRY_COUNT);
    localparam int CLR_COUNT    = (BUCKET_COUNT > ENTRY_COUNT) ? BUCKET_COUNT : ENTRY_COUNT;
    localparam int CLR_W        = $clog2(CLR_COUNT);

    localparam logic [7:0] PROTO_ICMP    = 8'd1;
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] OPEN_MASK     = 8'h12;
    localparam logic [7:0] OPEN_BARE_SYN = 8'h02;
    localparam logic [7:0] EGR_FLAG_MASK = 8'h0F;

    localparam logic [1:0] ST_NOT_LOCAL = 2'd0;
    localparam logic [1:0] ST_UPDATED   = 2'd1;
    localparam logic [1:0] ST_CREATED   = 2'd2;

    localparam logic [1:0] SEQ_NONE     = 2'd0;
    localparam logic [1:0] SEQ_IN_ORDER = 2'd1;
    localparam logic [1:0] SEQ_OOO      = 2'd2;
    localparam logic [1:0] SEQ_REPAIRED = 2'd3;

    localparam logic [1:0] FS_FIRST = 2'd1;
    localparam logic [1:0] FS_LATER = 2'd2;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] ident;
        logic [15:0] packet_length;
        logic [7:0]  tcp_flags;
        logic [31:0] tcp_sequence;
        logic [15:0] payload_offset;
        logic [63:0] timestamp;
        logic        payload_starts_http;
    } t_in;

    typedef struct packed {
        logic [1:0]  lookup_status;
        logic [11:0] entry_index;
        logic        is_ingress;
        logic [1:0]  sequence_check;
        logic        already_open;
        logic        overwrote_oldest;
    } t_out;

    typedef struct packed {
        logic [7:0]  proto;
        logic [31:0] lip;
        logic [31:0] rip;
        logic [15:0] lp;
        logic [15:0] rp;
        logic [15:0] id;
    } t_key;

    typedef struct packed {
        logic               used;
        logic [ENTRY_W-1:0] at;
    } t_link;

    typedef struct packed {
        logic [7:0]  flags;
        logic [31:0] remote_seq;
        logic [1:0]  status;
    } t_fseq;

    typedef struct packed {
        logic             local_hit;
        logic             ingress;
        t_key             key;
        logic [BKT_W-1:0] bucket;
        logic [15:0]      len;
        logic [7:0]       flags;
        logic [31:0]      seq;
        logic [15:0]      poff;
        logic             http;
    } t_qitem;

    // back-end status seen by the front end
    typedef struct packed {
        logic clearing;
    } t_bk_status;

    function automatic logic [BKT_W-1:0] bucket_of(t_key k);
        logic [31:0] h;
        h = k.lip ^ k.rip ^ {16'd0, k.lp} ^ {16'd0, k.rp} ^ {16'd0, k.id};
        return h[BKT_W-1:0];
    endfunction

endpackage

@@ hw/rtl/hftt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hftt_front: packet classifier and two-entry work queue
// Sets direction, normalizes the key, hashes it, queues it for the back end.
// ----------------------------------------------------------------------------
module hftt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_local_address,
    input  logic                i_valid,
    output logic                o_ready,
    input  hftt_pkg::t_in       i_data,
    input  hftt_pkg::t_bk_status i_status,
    output logic                o_q_valid,
    output hftt_pkg::t_qitem    o_q_item,
    input  logic                i_q_pop
);
    import hftt_pkg::*;

    t_qitem      r_q [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_cnt;
    t_qitem      cls;
    logic        push;

    always_comb begin
        cls           = '0;
        cls.key.proto = i_data.protocol;
        cls.key.id    = i_data.ident;
        cls.len       = i_data.packet_length;
        cls.flags     = i_data.tcp_flags;
        cls.seq       = i_data.tcp_sequence;
        cls.poff      = i_data.payload_offset;
        cls.http      = i_data.payload_starts_http;
        if (i_data.source_address == i_local_address) begin
            cls.local_hit = 1'b1;
            cls.key.lip   = i_data.source_address;
            cls.key.rip   = i_data.dest_address;
            cls.key.lp    = i_data.source_port;
            cls.key.rp    = i_data.dest_port;
        end else if (i_data.dest_address == i_local_address) begin
            cls.local_hit = 1'b1;
            cls.ingress   = 1'b1;
            cls.key.lip   = i_data.dest_address;
            cls.key.rip   = i_data.source_address;
            // ICMP keeps its fields in packet order
            if (i_data.protocol != PROTO_ICMP) begin
                cls.key.lp = i_data.dest_port;
                cls.key.rp = i_data.source_port;
            end else begin
                cls.key.lp = i_data.source_port;
                cls.key.rp = i_data.dest_port;
            end
        end
        cls.bucket = bucket_of(cls.key);
    end

    assign o_ready   = (r_cnt != 2'd2) && !i_status.clearing;
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

@@ hw/rtl/hftt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hftt_back: chain walker and flow table update engine
// Owns the bucket heads, the entry ring memories and the result register.
// ----------------------------------------------------------------------------
module hftt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  hftt_pkg::t_qitem     i_q_item,
    output logic                 o_q_pop,
    output hftt_pkg::t_bk_status o_status,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hftt_pkg::t_out       o_data
);
    import hftt_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_HEAD  = 10'b0000000010,
        S_CMP   = 10'b0000000100,
        S_MISS  = 10'b0000001000,
        S_VCHK  = 10'b0000010000,
        S_UHEAD = 10'b0000100000,
        S_UWALK = 10'b0001000000,
        S_WRITE = 10'b0010000000,
        S_AHEAD = 10'b0100000000,
        S_AWALK = 10'b1000000000
    } t_state;

    // memories
    t_link  m_head  [BUCKET_COUNT];
    t_link  m_next  [ENTRY_COUNT];
    logic   m_valid [ENTRY_COUNT];
    t_key   m_key   [ENTRY_COUNT];
    t_fseq  m_fseq  [ENTRY_COUNT];

    t_link  r_head_rd, r_next_rd;
    logic   r_valid_rd;
    t_key   r_key_rd;
    t_fseq  r_fseq_rd;

    t_state             r_state, n_state;
    t_qitem             r_it, n_it;
    logic [ENTRY_W-1:0] r_cur, n_cur;
    logic [ENTRY_W-1:0] r_prev, n_prev;
    logic [ENTRY_W-1:0] r_wp, n_wp;
    logic [BKT_W-1:0]   r_vb, n_vb;
    t_link              r_vnext, n_vnext;
    logic               r_over, n_over;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;
    logic               r_clr_busy;
    logic [CLR_W-1:0]   r_clr;

    logic [BKT_W-1:0]   head_ra, head_wa;
    logic [ENTRY_W-1:0] walk_ra, next_wa, ent_wa;
    logic               head_we, next_we, ent_we, valid_we;
    t_link              head_wd, next_wd;
    logic               valid_wd;
    t_key               key_wd;
    t_fseq              fseq_wd;
    logic               pop;
    logic               key_match;
    logic [ENTRY_W-1:0] wp_inc;
    logic [31:0]        seq_next;

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            m_head[head_wa] <= head_wd;
        end
        r_head_rd <= m_head[head_ra];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            m_next[next_wa] <= next_wd;
        end
        r_next_rd <= m_next[walk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (valid_we) begin
            m_valid[ent_wa] <= valid_wd;
        end
        r_valid_rd <= m_valid[walk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            m_key[ent_wa]  <= key_wd;
            m_fseq[ent_wa] <= fseq_wd;
        end
        r_key_rd  <= m_key[walk_ra];
        r_fseq_rd <= m_fseq[walk_ra];
    end

    assign o_status.clearing = r_clr_busy;
    assign o_q_pop = pop;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign key_match = r_valid_rd && (r_key_rd == r_it.key);
    assign wp_inc    = r_wp + ENTRY_W'(1);  // wraps at ENTRY_COUNT
    assign seq_next  = r_it.seq + {16'd0, r_it.len} - {16'd0, r_it.poff};

    always_comb begin
        n_state     = r_state;
        n_it        = r_it;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_wp        = r_wp;
        n_vb        = r_vb;
        n_vnext     = r_vnext;
        n_over      = r_over;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        pop         = 1'b0;
        head_ra     = r_it.bucket;
        walk_ra     = r_cur;
        head_we     = 1'b0;
        head_wa     = r_it.bucket;
        head_wd     = '0;
        next_we     = 1'b0;
        next_wa     = r_prev;
        next_wd     = '0;
        ent_we      = 1'b0;
        valid_we    = 1'b0;
        ent_wa      = r_cur;
        valid_wd    = 1'b0;
        key_wd      = r_it.key;
        fseq_wd     = r_fseq_rd;

        if (r_clr_busy) begin
            head_we  = ({1'b0, r_clr} < (CLR_W+1)'(BUCKET_COUNT));
            head_wa  = r_clr[BKT_W-1:0];
            next_we  = ({1'b0, r_clr} < (CLR_W+1)'(ENTRY_COUNT));
            next_wa  = r_clr[ENTRY_W-1:0];
            valid_we = next_we;
            ent_wa   = r_clr[ENTRY_W-1:0];
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    head_ra = i_q_item.bucket;
                    if (i_q_valid && !n_out_valid) begin
                        pop  = 1'b1;
                        n_it = i_q_item;
                        if (i_q_item.local_hit) begin
                            n_state = S_HEAD;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out       = '0;
                        end
                    end
                end
                S_HEAD: begin
                    walk_ra = r_head_rd.at;
                    n_cur   = r_head_rd.at;
                    n_state = r_head_rd.used ? S_CMP : S_MISS;
                end
                S_CMP: begin
                    walk_ra = r_next_rd.at;
                    if (key_match) begin
                        // hit: update flags and the ingress sequence check
                        ent_we          = 1'b1;
                        fseq_wd.status  = FS_LATER;
                        n_out           = '0;
                        n_out.lookup_status = ST_UPDATED;
                        n_out.entry_index   = 12'(r_cur);
                        n_out.is_ingress    = r_it.ingress;
                        if (r_it.key.proto == PROTO_TCP) begin
                            if (r_it.ingress) begin
                                fseq_wd.flags = r_fseq_rd.flags | {r_it.flags[3:0], 4'h0};
                                if (r_it.seq == r_fseq_rd.remote_seq) begin
                                    fseq_wd.remote_seq   = seq_next;
                                    n_out.sequence_check = SEQ_IN_ORDER;
                                end else if (r_it.http) begin
                                    fseq_wd.remote_seq   = seq_next;
                                    n_out.sequence_check = SEQ_REPAIRED;
                                end else begin
                                    n_out.sequence_check = SEQ_OOO;
                                end
                            end else begin
                                fseq_wd.flags = r_fseq_rd.flags | r_it.flags;
                            end
                        end
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else if (r_next_rd.used) begin
                        n_cur = r_next_rd.at;
                    end else begin
                        n_state = S_MISS;
                    end
                end
                S_MISS: begin
                    walk_ra = wp_inc;
                    n_cur   = wp_inc;
                    n_wp    = wp_inc;
                    n_over  = 1'b0;
                    n_state = S_VCHK;
                end
                S_VCHK: begin
                    head_ra = bucket_of(r_key_rd);
                    n_vb    = bucket_of(r_key_rd);
                    n_vnext = r_next_rd;
                    if (r_valid_rd) begin
                        n_over  = 1'b1;
                        n_state = S_UHEAD;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
                S_UHEAD: begin
                    walk_ra = r_head_rd.at;
                    n_prev  = r_head_rd.at;
                    if (r_head_rd.used && r_head_rd.at == r_cur) begin
                        head_we = 1'b1;
                        head_wa = r_vb;
                        head_wd = r_vnext;
                        n_state = S_WRITE;
                    end else if (r_head_rd.used) begin
                        n_state = S_UWALK;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
                S_UWALK: begin
                    walk_ra = r_next_rd.at;
                    n_prev  = r_next_rd.at;
                    if (r_next_rd.used && r_next_rd.at == r_cur) begin
                        next_we = 1'b1;
                        next_wa = r_prev;
                        next_wd = r_vnext;
                        n_state = S_WRITE;
                    end else if (!r_next_rd.used) begin
                        n_state = S_WRITE;
                    end
                end
                S_WRITE: begin
                    // new entry goes into the victim slot
                    ent_we   = 1'b1;
                    valid_we = 1'b1;
                    valid_wd = 1'b1;
                    next_we  = 1'b1;
                    next_wa  = r_cur;
                    next_wd  = '0;
                    fseq_wd.remote_seq = '0;
                    fseq_wd.status     = FS_FIRST;
                    fseq_wd.flags      = r_it.ingress ? {r_it.flags[3:0], 4'h0}
                                                      : (r_it.flags & EGR_FLAG_MASK);
                    n_state  = S_AHEAD;
                end
                S_AHEAD: begin
                    walk_ra = r_head_rd.at;
                    n_prev  = r_head_rd.at;
                    if (!r_head_rd.used) begin
                        head_we      = 1'b1;
                        head_wd.used = 1'b1;
                        head_wd.at   = r_cur;
                        n_state      = S_IDLE;
                        n_out_valid  = 1'b1;
                    end else begin
                        n_state = S_AWALK;
                    end
                end
                S_AWALK: begin
                    walk_ra = r_next_rd.at;
                    if (!r_next_rd.used) begin
                        next_we      = 1'b1;
                        next_wa      = r_prev;
                        next_wd.used = 1'b1;
                        next_wd.at   = r_cur;
                        n_state      = S_IDLE;
                        n_out_valid  = 1'b1;
                    end else begin
                        n_prev = r_next_rd.at;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
            if (n_out_valid && (r_state == S_AHEAD || r_state == S_AWALK)) begin
                n_out                  = '0;
                n_out.lookup_status    = ST_CREATED;
                n_out.entry_index      = 12'(r_cur);
                n_out.is_ingress       = r_it.ingress;
                n_out.already_open     = (r_it.key.proto == PROTO_TCP) &&
                                         ((r_it.flags & OPEN_MASK) != OPEN_BARE_SYN);
                n_out.overwrote_oldest = r_over;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_it    <= n_it;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_vb    <= n_vb;
        r_vnext <= n_vnext;
        r_over  <= n_over;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '1;
            r_out_valid <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr       <= '0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_out_valid <= n_out_valid;
            if (r_clr_busy) begin
                r_clr <= r_clr + CLR_W'(1);
                if (r_clr == CLR_W'(CLR_COUNT - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !pop)
        else $error("queue popped during clearing pass");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.lookup_status != 2'd3))
        else $error("illegal lookup status");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.lookup_status == ST_UPDATED)
            |-> (!r_out.already_open && !r_out.overwrote_oldest))
        else $error("hit result carries new-flow flags");

    a_wp_only_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MISS) |=> $stable(r_wp))
        else $error("write pointer moved outside miss handling");

endmodule

@@ hw/rtl/hashed_flow_table_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_flow_table_tracker: five-tuple flow cache with chained hashing
// Tracks flows of one monitored IPv4 host in a ring of flow entries.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_data) takes one parsed
//    packet header per transaction; output channel (o_out_valid /
//    i_out_ready / o_out_data) returns exactly one result per packet.
//  - local_address is written over the APB port at byte address 0; write it
//    only while the block is idle.
//  - From the queue, a not-local packet goes straight to the output
//    register; a hit walks the target chain to its entry; a new flow walks
//    the whole target chain for the lookup and again for the append, plus
//    the steps of the victim-chain walk when a valid entry is overwritten.
//    Throughput is set by the single back-end walker: one memory read per
//    chain step.
//  - A two-entry queue sits between the classifier and the walker, so new
//    packets are accepted while the walker or the output register stalls.
//  - After reset the bucket heads, links and valid bits are cleared in a
//    pass over all CLR_COUNT addresses; o_in_ready stays low until it ends.
//  - When the receiver stalls, the result is held in the output register
//    and the walker waits before taking the next queued packet.
// ----------------------------------------------------------------------------
module hashed_flow_table_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  hftt_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hftt_pkg::t_out   o_out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import hftt_pkg::*;

    localparam logic REG_LOCAL_ADDR = 1'b0;

    logic [31:0] r_local_address;
    logic        q_valid, q_pop;
    t_qitem      q_item;
    t_bk_status  bk_status;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LOCAL_ADDR) ? r_local_address : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= 32'd0;
        end else if (psel && penable && pwrite && paddr[2] == REG_LOCAL_ADDR) begin
            r_local_address <= pwdata;
        end
    end

    // front end: direction, key normalization, hash, queue
    hftt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_local_address (r_local_address),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_data          (i_in_data),
        .i_status        (bk_status),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    // back end: chain walk, entry update or creation, result register
    hftt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_item (q_item),
        .o_q_pop  (q_pop),
        .o_status (bk_status),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (o_out_data)
    );

endmodule

@@ test/hftt_flow_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hftt_flow_checker: result predictor and scoreboard for the flow tracker
// Follows accepted packets and APB writes, keeps its own flow table and
// compares every returned result with the oldest expected one.
// ----------------------------------------------------------------------------
module hftt_flow_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  hftt_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  hftt_pkg::t_out i_out_data,
    input  logic           i_psel,
    input  logic           i_penable,
    input  logic           i_pwrite,
    input  logic           i_pready,
    input  logic [2:0]     i_paddr,
    input  logic [31:0]    i_pwdata,
    output int             o_errors,
    output int             o_pending
);
    import hftt_pkg::*;

    localparam logic [2:0] ADDR_LOCAL = 3'd0;

    logic [31:0]        loc_addr;
    logic               head_used [BUCKET_COUNT];
    logic [ENTRY_W-1:0] head_at   [BUCKET_COUNT];
    logic               nxt_used  [ENTRY_COUNT];
    logic [ENTRY_W-1:0] nxt_at    [ENTRY_COUNT];
    logic               flow_vld  [ENTRY_COUNT];
    t_key               flow_key  [ENTRY_COUNT];
    logic [31:0]        flow_rseq [ENTRY_COUNT];
    logic [ENTRY_W-1:0] ring_ptr;
    t_out               expected_results[$];

    function automatic logic [BKT_W-1:0] hash_key(t_key k);
        logic [31:0] h;
        h = k.lip ^ k.rip ^ {16'd0, k.lp} ^ {16'd0, k.rp} ^ {16'd0, k.id};
        return h[BKT_W-1:0];
    endfunction

    // remove a victim slot from its chain before it is reused
    function automatic void drop_victim(logic [ENTRY_W-1:0] v);
        logic [BKT_W-1:0]   b;
        logic               cu;
        logic [ENTRY_W-1:0] ca;
        logic               have_prev;
        logic [ENTRY_W-1:0] prev;
        int                 steps;
        b = hash_key(flow_key[v]);
        cu = head_used[b];
        ca = head_at[b];
        have_prev = 1'b0;
        prev = '0;
        steps = 0;
        while (cu && steps < ENTRY_COUNT) begin
            if (ca == v) begin
                if (have_prev) begin
                    nxt_used[prev] = nxt_used[v];
                    nxt_at[prev]   = nxt_at[v];
                end else begin
                    head_used[b] = nxt_used[v];
                    head_at[b]   = nxt_at[v];
                end
                break;
            end
            have_prev = 1'b1;
            prev = ca;
            cu = nxt_used[ca];
            ca = nxt_at[ca];
            steps++;
        end
        flow_vld[v] = 1'b0;
        nxt_used[v] = 1'b0;
        nxt_at[v]   = '0;
    endfunction

    function automatic t_out track_packet(t_in p);
        t_out               r;
        t_key               k;
        logic               ingress;
        logic [BKT_W-1:0]   b;
        logic               cu;
        logic [ENTRY_W-1:0] ca;
        logic               hit;
        logic [ENTRY_W-1:0] idx;
        logic [ENTRY_W-1:0] tail;
        int                 steps;
        r = '0;
        k.proto = p.protocol;
        k.id    = p.ident;
        if (p.source_address == loc_addr) begin
            ingress = 1'b0;
            k.lip = p.source_address; k.rip = p.dest_address;
            k.lp  = p.source_port;    k.rp  = p.dest_port;
        end else if (p.dest_address == loc_addr) begin
            ingress = 1'b1;
            k.lip = p.dest_address; k.rip = p.source_address;
            if (p.protocol != PROTO_ICMP) begin
                k.lp = p.dest_port;   k.rp = p.source_port;
            end else begin
                k.lp = p.source_port; k.rp = p.dest_port;
            end
        end else begin
            return r;
        end
        r.is_ingress = ingress;

        b = hash_key(k);
        cu = head_used[b];
        ca = head_at[b];
        hit = 1'b0;
        idx = '0;
        steps = 0;
        while (cu && steps < ENTRY_COUNT) begin
            if (flow_vld[ca] && flow_key[ca] == k) begin
                hit = 1'b1;
                idx = ca;
                break;
            end
            cu = nxt_used[ca];
            ca = nxt_at[ca];
            steps++;
        end

        if (hit) begin
            r.lookup_status = ST_UPDATED;
            if (ingress && p.protocol == PROTO_TCP) begin
                if (p.tcp_sequence == flow_rseq[idx]) begin
                    r.sequence_check = SEQ_IN_ORDER;
                    flow_rseq[idx] = p.tcp_sequence + p.packet_length - p.payload_offset;
                end else if (p.payload_starts_http) begin
                    r.sequence_check = SEQ_REPAIRED;
                    flow_rseq[idx] = p.tcp_sequence + p.packet_length - p.payload_offset;
                end else begin
                    r.sequence_check = SEQ_OOO;
                end
            end
        end else begin
            r.lookup_status = ST_CREATED;
            idx = ring_ptr + 1'b1;   // wraps at ENTRY_COUNT
            ring_ptr = idx;
            if (flow_vld[idx]) begin
                r.overwrote_oldest = 1'b1;
                drop_victim(idx);
            end
            flow_key[idx]  = k;
            flow_vld[idx]  = 1'b1;
            nxt_used[idx]  = 1'b0;
            nxt_at[idx]    = '0;
            flow_rseq[idx] = '0;
            r.already_open = (p.protocol == PROTO_TCP) &&
                             ((p.tcp_flags & OPEN_MASK) != OPEN_BARE_SYN);
            if (!head_used[b]) begin
                head_used[b] = 1'b1;
                head_at[b]   = idx;
            end else begin
                tail = head_at[b];
                steps = 0;
                while (nxt_used[tail] && steps < ENTRY_COUNT) begin
                    tail = nxt_at[tail];
                    steps++;
                end
                nxt_used[tail] = 1'b1;
                nxt_at[tail]   = idx;
            end
        end
        r.entry_index = 12'(idx);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: MISMATCH %s got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            loc_addr = '0;
            ring_ptr = '1;
            for (int i = 0; i < BUCKET_COUNT; i++) head_used[i] = 1'b0;
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                nxt_used[i] = 1'b0;
                flow_vld[i] = 1'b0;
            end
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_LOCAL)
                loc_addr = i_pwdata;
            if (i_in_valid && i_in_ready)
                expected_results.push_back(track_packet(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, queue size", 0, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.lookup_status != want.lookup_status)
                        report_mismatch("lookup_status", i_out_data.lookup_status,
                                        want.lookup_status);
                    if (i_out_data.entry_index != want.entry_index)
                        report_mismatch("entry_index", i_out_data.entry_index,
                                        want.entry_index);
                    if (i_out_data.is_ingress != want.is_ingress)
                        report_mismatch("is_ingress", i_out_data.is_ingress, want.is_ingress);
                    if (i_out_data.sequence_check != want.sequence_check)
                        report_mismatch("sequence_check", i_out_data.sequence_check,
                                        want.sequence_check);
                    if (i_out_data.already_open != want.already_open)
                        report_mismatch("already_open", i_out_data.already_open,
                                        want.already_open);
                    if (i_out_data.overwrote_oldest != want.overwrote_oldest)
                        report_mismatch("overwrote_oldest", i_out_data.overwrote_oldest,
                                        want.overwrote_oldest);
                end
            end
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

endmodule

@@ test/tb_hashed_flow_table_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_flow_table_tracker: stimulus and verdict for the flow tracker
// Directed packets, then random flow traffic under several local addresses,
// then a final run of mostly new flows with no idling at its end. A checker
// module beside the block predicts and compares each result transaction.
// ----------------------------------------------------------------------------
module tb_hashed_flow_table_tracker;
    import hftt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;  // covers the clear pass after reset
    localparam int POOL_SIZE      = 32;
    localparam logic [2:0] ADDR_LOCAL = 3'd0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_data;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;
    int          stall_cycles = 0;
    bit          quiet = 1'b0;       // no idling on either side
    logic [31:0] cur_local = '0;

    // flow pool used to produce repeated hits
    logic [7:0]  pool_proto [POOL_SIZE];
    logic [31:0] pool_rip   [POOL_SIZE];
    logic [15:0] pool_lp    [POOL_SIZE];
    logic [15:0] pool_rp    [POOL_SIZE];
    logic [15:0] pool_id    [POOL_SIZE];
    logic [31:0] pool_nseq  [POOL_SIZE];

    always #1 i_clk = ~i_clk;

    hashed_flow_table_tracker uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    hftt_flow_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    // receiver: ready drops in bursts of random length unless quiet
    always @(negedge i_clk) begin
        if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            out_ready <= 1'b0;
        end else if (!quiet && i_rst_n && $urandom_range(0, 5) == 0) begin
            stall_cycles <= $urandom_range(0, 5);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // watchdog: cycles without any transaction on either channel
    always @(posedge i_clk) begin
        int idle_run;
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
        else idle_run++;
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one packet transaction; valid stays high across back-to-back packets
    task automatic send_packet(input t_in p);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            @(negedge i_clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // APB write once every result has come back
    task automatic write_local(input logic [31:0] value);
        @(negedge i_clk) in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_LOCAL; pwdata <= value;
        @(negedge i_clk) penable <= 1'b1;
        @(negedge i_clk) begin
            psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        end
        cur_local = value;
    endtask

    function automatic t_in make_pkt(logic [7:0] proto, logic [31:0] sa, logic [31:0] da,
                                     logic [15:0] sp, logic [15:0] dp, logic [15:0] id,
                                     logic [15:0] len, logic [7:0] fl, logic [31:0] seq,
                                     logic [15:0] poff, logic http);
        t_in p;
        p.protocol = proto;  p.source_address = sa; p.dest_address = da;
        p.source_port = sp;  p.dest_port = dp;      p.ident = id;
        p.packet_length = len; p.tcp_flags = fl;    p.tcp_sequence = seq;
        p.payload_offset = poff; p.timestamp = {$urandom, $urandom};
        p.payload_starts_http = http;
        return p;
    endfunction

    function automatic logic [31:0] other_addr();
        logic [31:0] a;
        do a = $urandom; while (a == cur_local);
        return a;
    endfunction

    // half the flows share a bucket: only the high remote address bits vary
    function automatic void new_flow(int i);
        case ($urandom_range(0, 3))
            0:       pool_proto[i] = PROTO_TCP;
            1:       pool_proto[i] = 8'd17;
            2:       pool_proto[i] = PROTO_ICMP;
            default: pool_proto[i] = 8'($urandom);
        endcase
        if ($urandom_range(0, 1)) begin
            pool_rip[i] = {$urandom_range(0, 7) == 0 ? 20'hFFFFF : 20'($urandom), 12'h5A5};
            pool_lp[i] = 16'd80; pool_rp[i] = 16'd1234; pool_id[i] = 16'd7;
        end else begin
            pool_rip[i] = $urandom;
            pool_lp[i] = 16'($urandom); pool_rp[i] = 16'($urandom);
            pool_id[i] = 16'($urandom);
        end
        if (pool_rip[i] == cur_local) pool_rip[i] = ~cur_local;
        pool_nseq[i] = '0;
    endfunction

    // packet of a pooled flow, either direction, sequence mostly in order
    task automatic send_pool_pkt(int i);
        logic        ingress;
        logic [15:0] len, poff;
        logic [31:0] seq;
        t_in         p;
        ingress = 1'($urandom_range(0, 1));
        len  = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(40, 1500));
        poff = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(20, 60));
        seq  = $urandom_range(0, 9) < 7 ? pool_nseq[i] : $urandom;
        if (!ingress)
            p = make_pkt(pool_proto[i], cur_local, pool_rip[i], pool_lp[i], pool_rp[i],
                         pool_id[i], len, 8'($urandom), $urandom, 16'($urandom),
                         1'($urandom));
        else if (pool_proto[i] == PROTO_ICMP)
            p = make_pkt(pool_proto[i], pool_rip[i], cur_local, pool_lp[i], pool_rp[i],
                         pool_id[i], len, 8'($urandom), seq, poff,
                         $urandom_range(0, 3) == 0);
        else
            p = make_pkt(pool_proto[i], pool_rip[i], cur_local, pool_rp[i], pool_lp[i],
                         pool_id[i], len, 8'($urandom), seq, poff,
                         $urandom_range(0, 3) == 0);
        // next in-order guess; a repaired or in-order packet reloads it
        if (ingress && (seq == pool_nseq[i] || p.payload_starts_http))
            pool_nseq[i] = seq + len - poff;
        send_packet(p);
    endtask

    task automatic send_random_item();
        logic [31:0] a;
        case ($urandom_range(0, 19))
            0, 1:                                    // neither side local
                send_packet(make_pkt(8'($urandom), other_addr(), other_addr(),
                                     16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 8'($urandom), $urandom,
                                     16'($urandom), 1'($urandom)));
            2:                                       // both sides local
                send_packet(make_pkt(8'($urandom), cur_local, cur_local, 16'($urandom),
                                     16'($urandom), 16'($urandom), 16'($urandom),
                                     8'($urandom), $urandom, 16'($urandom),
                                     1'($urandom)));
            3, 4, 5: begin                           // arbitrary fields, one side local
                a = $urandom;
                if ($urandom_range(0, 1))
                    send_packet(make_pkt(8'($urandom), cur_local, a, 16'($urandom),
                                         16'($urandom), 16'($urandom), 16'($urandom),
                                         8'($urandom), $urandom, 16'($urandom),
                                         1'($urandom)));
                else
                    send_packet(make_pkt(8'($urandom), a, cur_local, 16'($urandom),
                                         16'($urandom), 16'($urandom), 16'($urandom),
                                         8'($urandom), $urandom, 16'($urandom),
                                         1'($urandom)));
            end
            default: begin                           // traffic of known flows
                int i;
                i = $urandom_range(0, POOL_SIZE - 1);
                if ($urandom_range(0, 9) == 0) new_flow(i);
                send_pool_pkt(i);
            end
        endcase
    endtask

    initial begin
        logic [31:0] la;
        logic [31:0] ra;
        la = 32'h0A000001;
        ra = 32'hC0A80002;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // ---------------- directed part ----------------
        write_local(la);
        // not local: all-zero and all-ones fields
        send_packet(make_pkt(8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                             32'h0, 16'h0, 1'b0));
        send_packet(make_pkt(8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1));
        // TCP egress bare SYN opens a flow; not already open
        send_packet(make_pkt(PROTO_TCP, la, ra, 16'd40000, 16'd80, 16'd1, 16'd60,
                             8'h02, 32'd0, 16'd40, 1'b0));
        // egress hit, all flags
        send_packet(make_pkt(PROTO_TCP, la, ra, 16'd40000, 16'd80, 16'd1, 16'd52,
                             8'hFF, 32'd99, 16'd40, 1'b0));
        // ingress hits: in order, in order, out of order, repaired, in order
        send_packet(make_pkt(PROTO_TCP, ra, la, 16'd80, 16'd40000, 16'd1, 16'd100,
                             8'h12, 32'd0, 16'd40, 1'b0));
        send_packet(make_pkt(PROTO_TCP, ra, la, 16'd80, 16'd40000, 16'd1, 16'd100,
                             8'h10, 32'd60, 16'd40, 1'b0));
        send_packet(make_pkt(PROTO_TCP, ra, la, 16'd80, 16'd40000, 16'd1, 16'd100,
                             8'h10, 32'd5000, 16'd40, 1'b0));
        send_packet(make_pkt(PROTO_TCP, ra, la, 16'd80, 16'd40000, 16'd1, 16'd100,
                             8'h18, 32'd7000, 16'd20, 1'b1));
        send_packet(make_pkt(PROTO_TCP, ra, la, 16'd80, 16'd40000, 16'd1, 16'hFFFF,
                             8'h10, 32'd7080, 16'd0, 1'b0));
        // new ingress TCP with ACK only, and with SYN+ACK: both already open
        send_packet(make_pkt(PROTO_TCP, ra, la, 16'd443, 16'd50000, 16'd2, 16'd60,
                             8'h10, 32'd1, 16'd40, 1'b0));
        send_packet(make_pkt(PROTO_TCP, ra, la, 16'd444, 16'd50000, 16'd2, 16'd60,
                             8'h12, 32'd1, 16'd40, 1'b0));
        // sequence wraps past 2^32 on reload
        send_packet(make_pkt(PROTO_TCP, ra, la, 16'd444, 16'd50000, 16'd2, 16'd200,
                             8'h10, 32'hFFFFFFF0, 16'd0, 1'b1));
        send_packet(make_pkt(PROTO_TCP, ra, la, 16'd444, 16'd50000, 16'd2, 16'd10,
                             8'h10, 32'h000000B8, 16'd0, 1'b0));
        // UDP egress creates, ingress hits with swapped ports
        send_packet(make_pkt(8'd17, la, ra, 16'd53, 16'd5353, 16'd3, 16'd80, 8'h00,
                             32'd0, 16'd8, 1'b0));
        send_packet(make_pkt(8'd17, ra, la, 16'd5353, 16'd53, 16'd3, 16'd80, 8'h00,
                             32'd0, 16'd8, 1'b0));
        // ICMP ingress keeps port order; the egress echo with the same order hits
        send_packet(make_pkt(PROTO_ICMP, ra, la, 16'h0800, 16'h1234, 16'd4, 16'd84,
                             8'h00, 32'd0, 16'd0, 1'b0));
        send_packet(make_pkt(PROTO_ICMP, la, ra, 16'h0800, 16'h1234, 16'd4, 16'd84,
                             8'h00, 32'd0, 16'd0, 1'b0));
        // both addresses local: egress
        send_packet(make_pkt(PROTO_TCP, la, la, 16'd1, 16'd2, 16'd5, 16'd40, 8'h02,
                             32'd0, 16'd40, 1'b0));
        send_packet(make_pkt(PROTO_TCP, la, la, 16'd2, 16'd1, 16'd5, 16'd40, 8'h02,
                             32'd0, 16'd40, 1'b0));
        // extremes of every field on a local packet
        send_packet(make_pkt(8'hFF, 32'hFFFFFFFF, la, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1));
        send_packet(make_pkt(8'h00, la, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                             32'h0, 16'h0, 1'b0));

        // ---------------- random part, several local addresses ----------------
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_local(32'h00000000);
                1: write_local(32'hFFFFFFFF);
                2: write_local($urandom);
                default: write_local(32'hC0A80001);
            endcase
            for (int i = 0; i < POOL_SIZE; i++) new_flow(i);
            for (int n = 0; n < 75; n++) send_random_item();
        end

        // ---------------- mostly new flows; idling stops toward the end --------
        write_local(la);
        for (int i = 0; i < POOL_SIZE; i++) new_flow(i);
        for (int n = 0; n < 80; n++) begin
            if (n == 60) quiet = 1'b1;       // no idling toward the end
            if ($urandom_range(0, 4) == 0) begin
                send_pool_pkt($urandom_range(0, POOL_SIZE - 1));
            end else begin
                ra = other_addr();
                send_packet(make_pkt($urandom_range(0, 1) ? PROTO_TCP : 8'($urandom),
                                     la, ra, 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom), 8'($urandom),
                                     $urandom, 16'($urandom), 1'($urandom)));
            end
        end

        @(negedge i_clk) in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ hashed_flow_table_tracker.f @@
hw/rtl/hftt_pkg.sv
hw/rtl/hftt_front.sv
hw/rtl/hftt_back.sv
hw/rtl/hashed_flow_table_tracker.sv
test/hftt_flow_checker.sv
test/tb_hashed_flow_table_tracker.sv
